### rtl/i2cmbs_pkg.sv
package i2cmbs_pkg;

  // bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ST1    = 4'd1,
    PH_ST2    = 4'd2,
    PH_SP1    = 4'd3,
    PH_SP2    = 4'd4,
    PH_WA1    = 4'd5,
    PH_WA2    = 4'd6,
    PH_POLL   = 4'd7,
    PH_W_LOW  = 4'd8,
    PH_W_HIGH = 4'd9,
    PH_W_TAIL = 4'd10,
    PH_R_LOW  = 4'd11,
    PH_R_HIGH = 4'd12,
    PH_A_LOW  = 4'd13,
    PH_A_HIGH = 4'd14
  } phase_t;

  // command codes
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WAIT_ACK = 3'd5
  } cmd_t;

  // configuration register indexes
  localparam logic CFG_TICKS_PER_UNIT = 1'b0;
  localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

  localparam logic [7:0] TICKS_PER_UNIT_RST = 8'd1;
  localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd250;

  // delay lengths as shift amounts: 1, 2 and 4 units
  localparam logic [1:0] UNITS_1 = 2'd0;
  localparam logic [1:0] UNITS_2 = 2'd1;
  localparam logic [1:0] UNITS_4 = 2'd2;

  localparam int DATA_W = 16;

  // sequencer state
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  bit_count;
    logic [7:0]  shift_byte;
    logic [9:0]  delay_count;
    logic [7:0]  poll_count;
    logic        ack_choice;
    logic        scl;
    logic        sda;
    logic        sda_oe;
    logic        timeout;
    logic [7:0]  rx_hold;
  } seq_state_t;

  // one result beat
  typedef struct packed {
    logic        ack_missing;
    logic [7:0]  rx_byte;
    logic        done_res;
    logic        busy_res;
    logic        sda_enable;
    logic        sda_level;
    logic        scl_level;
  } result_t;

  // delay length in ticks, a zero unit counts as one tick
  function automatic logic [9:0] wait_ticks(input logic [7:0] tpu, input logic [1:0] shift);
    logic [9:0] t;
    t = (tpu == 8'd0) ? 10'd1 : {2'b00, tpu};
    return t << shift;
  endfunction

endpackage

### rtl/i2cmbs_step.sv
module i2cmbs_step (
  input  i2cmbs_pkg::seq_state_t st,
  input  logic [2:0]             command,
  input  logic [7:0]             tx_byte,
  input  logic                   send_ack,
  input  logic                   sda_sample,
  input  logic [7:0]             ticks_per_unit,
  input  logic [7:0]             ack_poll_limit,
  output i2cmbs_pkg::seq_state_t st_next,
  output logic                   done
);

  logic [9:0] delay_dec;

  assign delay_dec = (st.delay_count != 10'd0) ? st.delay_count - 10'd1 : 10'd0;

  // one tick of the sequencer
  always_comb begin
    st_next = st;
    done    = 1'b0;
    if (st.phase == i2cmbs_pkg::PH_IDLE) begin
      // take a new command
      case (i2cmbs_pkg::cmd_t'(command))
        i2cmbs_pkg::CMD_START: begin
          st_next.sda_oe      = 1'b1;
          st_next.sda         = 1'b1;
          st_next.scl         = 1'b1;
          st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_4);
          st_next.phase       = i2cmbs_pkg::PH_ST1;
        end
        i2cmbs_pkg::CMD_STOP: begin
          st_next.sda_oe      = 1'b1;
          st_next.scl         = 1'b0;
          st_next.sda         = 1'b0;
          st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_4);
          st_next.phase       = i2cmbs_pkg::PH_SP1;
        end
        i2cmbs_pkg::CMD_WRITE: begin
          st_next.sda_oe      = 1'b1;
          st_next.scl         = 1'b0;
          st_next.bit_count   = 3'd0;
          st_next.sda         = tx_byte[7];
          st_next.shift_byte  = {tx_byte[6:0], 1'b0};
          st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_2);
          st_next.phase       = i2cmbs_pkg::PH_W_LOW;
        end
        i2cmbs_pkg::CMD_READ: begin
          st_next.sda_oe      = 1'b0;
          st_next.scl         = 1'b0;
          st_next.ack_choice  = send_ack;
          st_next.shift_byte  = 8'd0;
          st_next.bit_count   = 3'd0;
          st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_2);
          st_next.phase       = i2cmbs_pkg::PH_R_LOW;
        end
        i2cmbs_pkg::CMD_WAIT_ACK: begin
          st_next.sda_oe      = 1'b0;
          st_next.sda         = 1'b1;
          st_next.poll_count  = 8'd0;
          st_next.timeout     = 1'b0;
          st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_1);
          st_next.phase       = i2cmbs_pkg::PH_WA1;
        end
        default: begin
        end
      endcase
    end else if (st.phase == i2cmbs_pkg::PH_POLL ||
                 (st.phase == i2cmbs_pkg::PH_WA2 && delay_dec == 10'd0)) begin
      // ack poll, one per tick
      st_next.delay_count = delay_dec;
      if (!sda_sample) begin
        st_next.scl     = 1'b0;
        st_next.timeout = 1'b0;
        st_next.phase   = i2cmbs_pkg::PH_IDLE;
        done            = 1'b1;
      end else if (st.poll_count >= ack_poll_limit) begin
        st_next.timeout     = 1'b1;
        st_next.sda_oe      = 1'b1;
        st_next.scl         = 1'b0;
        st_next.sda         = 1'b0;
        st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_4);
        st_next.phase       = i2cmbs_pkg::PH_SP1;
      end else begin
        st_next.poll_count = st.poll_count + 8'd1;
        st_next.phase      = i2cmbs_pkg::PH_POLL;
      end
      if (st.phase == i2cmbs_pkg::PH_POLL) begin
        st_next.delay_count = (st_next.phase == i2cmbs_pkg::PH_SP1) ?
          st_next.delay_count : st.delay_count;
      end
    end else begin
      // count down the running delay, then step the phase
      st_next.delay_count = delay_dec;
      if (delay_dec == 10'd0) begin
        case (st.phase)
          i2cmbs_pkg::PH_ST1: begin
            st_next.sda         = 1'b0;
            st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_4);
            st_next.phase       = i2cmbs_pkg::PH_ST2;
          end
          i2cmbs_pkg::PH_ST2: begin
            st_next.scl   = 1'b0;
            st_next.phase = i2cmbs_pkg::PH_IDLE;
            done          = 1'b1;
          end
          i2cmbs_pkg::PH_SP1: begin
            st_next.scl         = 1'b1;
            st_next.sda         = 1'b1;
            st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_4);
            st_next.phase       = i2cmbs_pkg::PH_SP2;
          end
          i2cmbs_pkg::PH_SP2: begin
            st_next.phase = i2cmbs_pkg::PH_IDLE;
            done          = 1'b1;
          end
          i2cmbs_pkg::PH_WA1: begin
            st_next.scl         = 1'b1;
            st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_1);
            st_next.phase       = i2cmbs_pkg::PH_WA2;
          end
          i2cmbs_pkg::PH_W_LOW: begin
            st_next.scl         = 1'b1;
            st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_2);
            st_next.phase       = i2cmbs_pkg::PH_W_HIGH;
          end
          i2cmbs_pkg::PH_W_HIGH: begin
            st_next.scl         = 1'b0;
            st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_2);
            st_next.phase       = i2cmbs_pkg::PH_W_TAIL;
          end
          i2cmbs_pkg::PH_W_TAIL: begin
            if (st.bit_count == 3'd7) begin
              st_next.phase = i2cmbs_pkg::PH_IDLE;
              done          = 1'b1;
            end else begin
              st_next.bit_count   = st.bit_count + 3'd1;
              st_next.sda         = st.shift_byte[7];
              st_next.shift_byte  = {st.shift_byte[6:0], 1'b0};
              st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_2);
              st_next.phase       = i2cmbs_pkg::PH_W_LOW;
            end
          end
          i2cmbs_pkg::PH_R_LOW: begin
            st_next.scl         = 1'b1;
            st_next.shift_byte  = {st.shift_byte[6:0], sda_sample};
            st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_1);
            st_next.phase       = i2cmbs_pkg::PH_R_HIGH;
          end
          i2cmbs_pkg::PH_R_HIGH: begin
            st_next.scl = 1'b0;
            if (st.bit_count == 3'd7) begin
              st_next.rx_hold     = st.shift_byte;
              st_next.sda_oe      = 1'b1;
              st_next.sda         = ~st.ack_choice;
              st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_2);
              st_next.phase       = i2cmbs_pkg::PH_A_LOW;
            end else begin
              st_next.bit_count   = st.bit_count + 3'd1;
              st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_2);
              st_next.phase       = i2cmbs_pkg::PH_R_LOW;
            end
          end
          i2cmbs_pkg::PH_A_LOW: begin
            st_next.scl         = 1'b1;
            st_next.delay_count = i2cmbs_pkg::wait_ticks(ticks_per_unit, i2cmbs_pkg::UNITS_2);
            st_next.phase       = i2cmbs_pkg::PH_A_HIGH;
          end
          i2cmbs_pkg::PH_A_HIGH: begin
            st_next.scl   = 1'b0;
            st_next.phase = i2cmbs_pkg::PH_IDLE;
            done          = 1'b1;
          end
          default: begin
            st_next.phase = i2cmbs_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

### rtl/i2cmbs_out_reg.sv
module i2cmbs_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [i2cmbs_pkg::DATA_W-1:0]  load_data,
  output logic                           free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [i2cmbs_pkg::DATA_W-1:0]  m_tdata
);

  // a new beat may enter when the held one is empty or leaving now
  assign free = ~m_tvalid | m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= load_data;
    end
  end

endmodule

### rtl/i2c_master_byte_sequencer.sv
// channel   dir  beat fields (low bit first)
// s_axis    in   command[2:0] tx_byte[10:3] send_ack[11] sda_sample[12], pad to 16
// m_axis    out  scl_level[0] sda_level[1] sda_enable[2] busy_res[3] done_res[4]
//                rx_byte[12:5] ack_missing[13], pad to 16
// cfg       in   cfg_we, cfg_index (0 ticks_per_unit, 1 ack_poll_limit), cfg_data[7:0]
//
// one input beat is one bus tick and is taken every cycle while s_tready is high;
// its result beat appears in the output register on the next cycle.
// the tick is stepped by the combinational sequencer next-state logic.
// reset: bus lines idle high and driven, sequencer idle, registers 1 and 250.
// a stall on m_axis holds the result and drops s_tready only while the
// output register is full and not being taken.
module i2c_master_byte_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // command, tx_byte, send_ack, sda_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_level, sda_level, sda_enable, busy_res,
                                 // done_res, rx_byte, ack_missing
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                   accept;
  logic [7:0]             ticks_per_unit;
  logic [7:0]             ack_poll_limit;
  i2cmbs_pkg::seq_state_t seq_state;
  i2cmbs_pkg::seq_state_t seq_state_next;
  logic                   done;
  i2cmbs_pkg::result_t    result;

  assign accept = s_tvalid & s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= i2cmbs_pkg::TICKS_PER_UNIT_RST;
      ack_poll_limit <= i2cmbs_pkg::ACK_POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cmbs_pkg::CFG_TICKS_PER_UNIT: ticks_per_unit <= cfg_data;
        i2cmbs_pkg::CFG_ACK_POLL_LIMIT: ack_poll_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // tick step logic
  i2cmbs_step u_step (
    .st             (seq_state),
    .command        (s_tdata[2:0]),
    .tx_byte        (s_tdata[10:3]),
    .send_ack       (s_tdata[11]),
    .sda_sample     (s_tdata[12]),
    .ticks_per_unit (ticks_per_unit),
    .ack_poll_limit (ack_poll_limit),
    .st_next        (seq_state_next),
    .done           (done)
  );

  // sequencer state, advanced once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state.phase       <= i2cmbs_pkg::PH_IDLE;
      seq_state.bit_count   <= 3'd0;
      seq_state.shift_byte  <= 8'd0;
      seq_state.delay_count <= 10'd0;
      seq_state.poll_count  <= 8'd0;
      seq_state.ack_choice  <= 1'b0;
      seq_state.scl         <= 1'b1;
      seq_state.sda         <= 1'b1;
      seq_state.sda_oe      <= 1'b1;
      seq_state.timeout     <= 1'b0;
      seq_state.rx_hold     <= 8'd0;
    end else if (accept) begin
      seq_state <= seq_state_next;
    end
  end

  // result beat from the updated state
  always_comb begin
    result.scl_level   = seq_state_next.scl;
    result.sda_level   = seq_state_next.sda;
    result.sda_enable  = seq_state_next.sda_oe;
    result.busy_res    = (seq_state_next.phase != i2cmbs_pkg::PH_IDLE);
    result.done_res    = done;
    result.rx_byte     = seq_state_next.rx_hold;
    result.ack_missing = seq_state_next.timeout;
  end

  i2cmbs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data ({2'b00, result}),
    .free      (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // a finishing tick never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[4] && m_tdata[3]))
    else $error("done and busy in the same result beat");

  // every accepted tick produces a result beat
  a_accept_gives_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted tick lost its result beat");

  // polling only with scl released high
  a_poll_scl_high: assert property (@(posedge clk) disable iff (rst)
    (seq_state.phase == i2cmbs_pkg::PH_POLL) |-> seq_state.scl)
    else $error("ack poll with scl low");

  // sda is released only during read, wait ack, or idle after them
  a_release_phase: assert property (@(posedge clk) disable iff (rst)
    !seq_state.sda_oe |->
      (seq_state.phase == i2cmbs_pkg::PH_IDLE   || seq_state.phase == i2cmbs_pkg::PH_R_LOW ||
       seq_state.phase == i2cmbs_pkg::PH_R_HIGH || seq_state.phase == i2cmbs_pkg::PH_WA1 ||
       seq_state.phase == i2cmbs_pkg::PH_WA2    || seq_state.phase == i2cmbs_pkg::PH_POLL))
    else $error("sda released in a driving phase");

  // state moves only on an accepted tick
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(seq_state))
    else $error("sequencer state changed without a tick");

endmodule
